// ----- design/dis_pkg.sv -----
`default_nettype none
package dis_pkg;
	localparam int MAX_INTERVALS = 32;
	localparam int IDX_W = $clog2(MAX_INTERVALS);
	localparam int CNT_W = $clog2(MAX_INTERVALS + 2);

	localparam logic [1:0] ST_APPLIED = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [31:0] left_bound;
		logic [31:0] right_bound;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        has_interval;
		logic [31:0] interval_left;
		logic [31:0] interval_right;
		logic        last_of_run;
	} res_t;

	typedef struct packed {
		logic signed [31:0] lo;
		logic signed [31:0] hi;
	} entry_t;
endpackage
`default_nettype wire

// ----- design/disjoint_interval_set_unit.sv -----
`default_nettype none
// Keeps a sorted set of disjoint half-open intervals in two banks of
// synchronous memory. A request is accepted when start is high and busy is
// low. The block then reads the current bank entry by entry and writes the
// new set into the other bank: a read (S_RD) and a process step (S_PROC) per
// stored interval, plus a second write (S_PUSH2) whenever an interval is split
// or a merged interval is placed ahead of a stored one, then a commit (S_FIN).
// If the new set fits, the banks swap; otherwise the old set stays and the
// status reports a full table. The whole set is then listed with a read
// (S_LRD) and an output (S_LOUT) per interval, and an empty set gives a
// single transfer without an interval. Each result is on res for exactly one
// cycle with res_valid high; the receiver cannot stall. busy falls in the
// cycle that carries the last transfer of the request, so the next request
// can be taken at the edge that ends it. A full table holds 32 intervals.
module disjoint_interval_set_unit (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire dis_pkg::req_t req,
	output logic             busy,
	output logic             res_valid,
	output dis_pkg::res_t    res
);
	import dis_pkg::*;

	// One-hot sequencer states.
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RD    = 7'b0000010,
		S_PROC  = 7'b0000100,
		S_PUSH2 = 7'b0001000,
		S_FIN   = 7'b0010000,
		S_LRD   = 7'b0100000,
		S_LOUT  = 7'b1000000
	} state_t;

	state_t state_q;

	// Two banks; bank_q names the bank that holds the live set.
	entry_t mem0 [MAX_INTERVALS];
	entry_t mem1 [MAX_INTERVALS];
	entry_t rdata0_q, rdata1_q;
	logic   bank_q;

	logic [CNT_W-1:0] cnt_q;     // live interval count
	logic [CNT_W-1:0] idx_q;     // read index for build and listing
	logic [CNT_W-1:0] wn_q;      // entries produced, saturates above the limit
	logic             op_q;
	logic signed [31:0] l_q, r_q;
	logic signed [31:0] ns_q, ne_q;   // interval being merged on an add
	logic [1:0]       phase_q;        // add: 0 before, 1 merging, 2 placed
	entry_t           p2_q;           // second write, held for S_PUSH2
	logic [1:0]       status_q;
	res_t             res_q;
	logic             res_valid_q;

	logic [IDX_W-1:0] raddr;
	entry_t           rd;
	logic             push;
	entry_t           push_d;
	logic             need2;
	entry_t           d2;
	logic             merge;
	logic             we;

	assign rd = bank_q ? rdata1_q : rdata0_q;
	assign raddr = idx_q[IDX_W-1:0];

	// Decide what one stored entry contributes to the new set.
	always_comb begin
		push   = 1'b0;
		push_d = rd;
		need2  = 1'b0;
		d2     = rd;
		merge  = 1'b0;
		case (state_q)
			S_PROC: begin
				if (op_q == REQ_ADD) begin
					if (phase_q == 2'd2) begin
						push = 1'b1;
					end else if (phase_q == 2'd0 && rd.hi < l_q) begin
						push = 1'b1;
					end else if (rd.lo <= r_q) begin
						merge = 1'b1;
					end else begin
						push      = 1'b1;
						push_d.lo = ns_q;
						push_d.hi = ne_q;
						need2     = 1'b1;
					end
				end else begin
					if (rd.hi <= l_q || rd.lo >= r_q) begin
						push = 1'b1;
					end else if (rd.lo < l_q) begin
						push      = 1'b1;
						push_d.hi = l_q;
						if (r_q < rd.hi) begin
							need2 = 1'b1;
							d2.lo = r_q;
						end
					end else if (r_q < rd.hi) begin
						push      = 1'b1;
						push_d.lo = r_q;
					end
				end
			end
			S_PUSH2: begin
				push   = 1'b1;
				push_d = p2_q;
			end
			S_FIN: begin
				push      = (op_q == REQ_ADD) && (phase_q != 2'd2);
				push_d.lo = ns_q;
				push_d.hi = ne_q;
			end
			default: begin
			end
		endcase
	end

	// Writes beyond the table are dropped; the saturated count flags them.
	assign we = push && (wn_q < CNT_W'(MAX_INTERVALS));

	always_ff @(posedge clk) begin
		if (we && bank_q) begin
			mem0[wn_q[IDX_W-1:0]] <= push_d;
		end
		if (we && !bank_q) begin
			mem1[wn_q[IDX_W-1:0]] <= push_d;
		end
		rdata0_q <= mem0[raddr];
		rdata1_q <= mem1[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bank_q      <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			wn_q        <= '0;
			phase_q     <= 2'd0;
			status_q    <= ST_APPLIED;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (push && wn_q <= CNT_W'(MAX_INTERVALS)) begin
				wn_q <= wn_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= req.req_type;
						l_q     <= req.left_bound;
						r_q     <= req.right_bound;
						ns_q    <= req.left_bound;
						ne_q    <= req.right_bound;
						phase_q <= 2'd0;
						idx_q   <= '0;
						wn_q    <= '0;
						if ($signed(req.left_bound) >= $signed(req.right_bound)) begin
							status_q <= ST_EMPTY;
							state_q  <= S_LRD;
						end else begin
							status_q <= ST_APPLIED;
							state_q  <= S_RD;
						end
					end
				end
				S_RD: begin
					// Read issued at idx_q; data arrives in S_PROC.
					if (idx_q == cnt_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_PROC;
					end
				end
				S_PROC: begin
					idx_q <= idx_q + 1'b1;
					if (merge) begin
						phase_q <= 2'd1;
						if (rd.lo < ns_q) ns_q <= rd.lo;
						if (rd.hi > ne_q) ne_q <= rd.hi;
					end
					if (need2) begin
						if (op_q == REQ_ADD) phase_q <= 2'd2;
						p2_q    <= d2;
						state_q <= S_PUSH2;
					end else begin
						state_q <= S_RD;
					end
				end
				S_PUSH2: begin
					state_q <= S_RD;
				end
				S_FIN: begin
					// For a remove phase_q is 0, but only adds place a merged interval.
					idx_q   <= '0;
					state_q <= S_LRD;
				end
				S_LRD: begin
					if (cnt_q == '0 && idx_q == '0) begin
						res_valid_q          <= 1'b1;
						res_q.status         <= status_q;
						res_q.has_interval   <= 1'b0;
						res_q.interval_left  <= '0;
						res_q.interval_right <= '0;
						res_q.last_of_run    <= 1'b1;
						state_q              <= S_IDLE;
					end else begin
						state_q <= S_LOUT;
					end
				end
				S_LOUT: begin
					res_valid_q          <= 1'b1;
					res_q.status         <= status_q;
					res_q.has_interval   <= 1'b1;
					res_q.interval_left  <= rd.lo;
					res_q.interval_right <= rd.hi;
					res_q.last_of_run    <= (idx_q + 1'b1 == cnt_q);
					idx_q                <= idx_q + 1'b1;
					if (idx_q + 1'b1 == cnt_q) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LRD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// Commit at the end of a build: swap banks if the new set fits.
			if (state_q == S_FIN) begin
				if (op_q == REQ_ADD && phase_q != 2'd2) begin
					if (wn_q + 1'b1 > CNT_W'(MAX_INTERVALS)) begin
						status_q <= ST_FULL;
					end else begin
						bank_q <= ~bank_q;
						cnt_q  <= wn_q + 1'b1;
					end
				end else begin
					if (wn_q > CNT_W'(MAX_INTERVALS)) begin
						status_q <= ST_FULL;
					end else begin
						bank_q <= ~bank_q;
						cnt_q  <= wn_q;
					end
				end
			end
		end
	end

	// In S_FIN a remove must not write the merged interval.
	assign busy      = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;
endmodule
`default_nettype wire
